>>> hdl/sacd_pkg.sv
// ----------------------------------------------------------------------------
// sacd_pkg
// Shared constants and types of the set-associative tag directory.
// ----------------------------------------------------------------------------
package sacd_pkg;

    localparam int SET_COUNT  = 1024;
    localparam int WAY_COUNT  = 8;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 32;
    localparam int TAG_W      = 16;
    localparam int AGE_W      = 3;
    localparam int WAY_W      = 3;
    localparam int OBITS      = $clog2(LINE_BYTES);
    localparam int IBITS      = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int SET_W      = IBITS;
    localparam int ENTRY_W    = 1 + 1 + AGE_W + TAG_W;
    localparam int ROW_W      = WAY_COUNT * ENTRY_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAY_COUNT - 1);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;

    localparam logic [2:0] OUT_HIT      = 3'd0;
    localparam logic [2:0] OUT_FILL     = 3'd1;
    localparam logic [2:0] OUT_EVICT    = 3'd2;
    localparam logic [2:0] OUT_INV_HIT  = 3'd3;
    localparam logic [2:0] OUT_INV_MISS = 3'd4;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef t_entry [WAY_COUNT-1:0] t_row;

    typedef struct packed {
        logic [2:0]       outcome;
        logic [WAY_W-1:0] way_used;
        logic             writeback;
        logic [TAG_W-1:0] victim_tag;
    } t_result;

endpackage

>>> hdl/sacd_ram.sv
// ----------------------------------------------------------------------------
// sacd_ram
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module sacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/sacd_update.sv
// ----------------------------------------------------------------------------
// sacd_update
// Lookup and replacement logic for one set row: hit, fill, evict, invalidate.
// ----------------------------------------------------------------------------
module sacd_update import sacd_pkg::*; (
    input  t_row             i_row,
    input  logic [1:0]       i_cmd,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_mode,
    output t_row             o_row,
    output t_result          o_res
);
    always_comb begin
        t_row             row;
        logic             hit, found, allm, wr;
        logic [WAY_W-1:0] hw, fw, vw;
        logic [AGE_W-1:0] cur, best;

        row   = i_row;
        wr    = (i_cmd == CMD_WRITE);
        hit   = 1'b0;
        hw    = '0;
        found = 1'b0;
        fw    = '0;
        allm  = 1'b1;
        best  = i_row[0].age;
        vw    = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (i_row[w].valid && i_row[w].tag == i_tag) begin
                hit = 1'b1;
                hw  = WAY_W'(w);
            end
            if (!i_row[w].valid) begin
                found = 1'b1;
                fw    = WAY_W'(w);
            end
            if (i_row[w].age == '0) begin
                allm = 1'b0;
            end
        end
        for (int w = 1; w < WAY_COUNT; w++) begin
            if (i_row[w].age > best) begin
                best = i_row[w].age;
                vw   = WAY_W'(w);
            end
        end
        cur   = i_row[hw].age;
        o_res = '0;

        if (i_cmd[1]) begin
            if (hit) begin
                o_res.outcome  = OUT_INV_HIT;
                o_res.way_used = hw;
                if (i_row[hw].dirty) begin
                    o_res.writeback  = 1'b1;
                    o_res.victim_tag = i_row[hw].tag;
                end
                if (!i_mode) begin
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (WAY_W'(w) != hw && i_row[w].valid && i_row[w].age > cur) begin
                            row[w].age = i_row[w].age - 1'b1;
                        end
                    end
                end
                row[hw] = '0;
            end else begin
                o_res.outcome = OUT_INV_MISS;
            end
        end else if (hit) begin
            o_res.outcome  = OUT_HIT;
            o_res.way_used = hw;
            if (wr) begin
                row[hw].dirty = 1'b1;
            end
            if (!i_mode) begin
                for (int w = 0; w < WAY_COUNT; w++) begin
                    if (i_row[w].valid && i_row[w].age < cur && i_row[w].age < AGE_MAX) begin
                        row[w].age = i_row[w].age + 1'b1;
                    end
                end
                row[hw].age = '0;
            end else begin
                row[hw].age = AGE_W'(1);
            end
        end else begin
            if (found) begin
                o_res.outcome = OUT_FILL;
                vw            = fw;
                if (!i_mode) begin
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (i_row[w].valid && i_row[w].age < AGE_MAX) begin
                            row[w].age = i_row[w].age + 1'b1;
                        end
                    end
                end
            end else begin
                o_res.outcome = OUT_EVICT;
                if (!i_mode) begin
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (i_row[w].age < AGE_MAX) begin
                            row[w].age = i_row[w].age + 1'b1;
                        end
                    end
                end else begin
                    vw = '0;
                    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
                        if (allm || i_row[w].age == '0) begin
                            vw = WAY_W'(w);
                        end
                    end
                end
                if (i_row[vw].dirty) begin
                    o_res.writeback  = 1'b1;
                    o_res.victim_tag = i_row[vw].tag;
                end
            end
            if (i_mode && allm) begin
                for (int w = 0; w < WAY_COUNT; w++) begin
                    row[w].age = '0;
                end
            end
            o_res.way_used = vw;
            row[vw].valid  = 1'b1;
            row[vw].dirty  = wr;
            row[vw].tag    = i_tag;
            row[vw].age    = i_mode ? AGE_W'(1) : '0;
        end
        o_row = row;
    end
endmodule

>>> hdl/set_assoc_cache_tag_directory.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_directory
// Tag directory of a write-back set-associative cache, rows held in one RAM.
// ----------------------------------------------------------------------------
// A request passes through accept, RAM read and row update before o_valid is raised.
// A new request is taken only once the last one has finished; busy is high while one is in flight.
// Reset: a clearing pass writes every row to zero, busy high.
// Results cannot be stalled: each is shown for one cycle with o_valid.
module set_assoc_cache_tag_directory import sacd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_cmd,
    input  logic [31:0]      i_address,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_replacement_mode,
    output logic             o_valid,
    output logic [2:0]       o_outcome,
    output logic [2:0]       o_way_used,
    output logic             o_writeback,
    output logic [15:0]      o_victim_tag
);
    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_UPD} t_state;

    t_state           r_state;
    logic [SET_W:0]   r_clr;
    logic [1:0]       r_cmd;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_mode;
    t_row             rd_row, up_row;
    t_result          res;
    logic             we;
    logic [SET_W-1:0] waddr, raddr;
    logic [ROW_W-1:0] wdata, rdata;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign raddr       = r_set;
    assign rd_row      = t_row'(rdata);
    assign we          = (r_state == ST_CLEAR) || (r_state == ST_UPD);
    assign waddr       = (r_state == ST_CLEAR) ? r_clr[SET_W-1:0] : r_set;
    assign wdata       = (r_state == ST_CLEAR) ? '0 : ROW_W'(up_row);

    sacd_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    sacd_update u_upd (
        .i_row (rd_row),
        .i_cmd (r_cmd),
        .i_tag (r_tag),
        .i_mode(r_mode),
        .o_row (up_row),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_mode  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_replacement_mode;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (SET_W+1)'(SET_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_set   <= i_address[OBITS +: SET_W];
                        r_tag   <= i_address[OBITS + SET_W +: TAG_W];
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    o_valid      <= 1'b1;
                    o_outcome    <= res.outcome;
                    o_way_used   <= res.way_used;
                    o_writeback  <= res.writeback;
                    o_victim_tag <= res.victim_tag;
                    r_state      <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> tb/cache_dir_checker.sv
// ----------------------------------------------------------------------------
// cache_dir_checker
// Watches the request, mode-write and result channels of the tag directory.
// Keeps its own copy of the tag, valid, dirty and age state per set and way.
// Predicts each result and compares all of its fields at once, in order.
// ----------------------------------------------------------------------------
module cache_dir_checker import sacd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_address,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_mode,
    input  logic        i_res_valid,
    input  logic [2:0]  i_outcome,
    input  logic [2:0]  i_way_used,
    input  logic        i_writeback,
    input  logic [15:0] i_victim_tag,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = SET_COUNT * WAY_COUNT;

    logic [TAG_W-1:0] dir_tag   [ENTRIES];
    logic             dir_valid [ENTRIES];
    logic             dir_dirty [ENTRIES];
    logic [AGE_W-1:0] dir_age   [ENTRIES];
    logic             plru_mode;
    t_result          lookup_q[$];

    function automatic void age_up(int e);
        if (dir_age[e] < AGE_MAX) dir_age[e] = dir_age[e] + 1'b1;
    endfunction

    function automatic void plru_clear_if_full(int base);
        bit full;
        full = 1;
        for (int w = 0; w < WAY_COUNT; w++) if (dir_age[base+w] == 0) full = 0;
        if (full) for (int w = 0; w < WAY_COUNT; w++) dir_age[base+w] = '0;
    endfunction

    function automatic t_result lookup(logic [1:0] cmd, logic [31:0] addr);
        t_result          r;
        int               base, e, hw, way;
        bit               hit, found, wr;
        logic [TAG_W-1:0] tg;
        logic [AGE_W-1:0] old, best;
        r    = '0;
        tg   = addr[OBITS+IBITS +: TAG_W];
        base = int'(addr[OBITS +: IBITS]) * WAY_COUNT;
        wr   = (cmd == CMD_WRITE);
        hit  = 0;
        hw   = 0;
        way  = 0;
        for (int w = 0; w < WAY_COUNT; w++)
            if (!hit && dir_valid[base+w] && dir_tag[base+w] == tg) begin
                hit = 1;
                hw  = w;
            end
        if (cmd != CMD_READ && cmd != CMD_WRITE) begin
            if (hit) begin
                e = base + hw;
                if (dir_dirty[e]) begin
                    r.writeback  = 1'b1;
                    r.victim_tag = dir_tag[e];
                end
                old = dir_age[e];
                dir_valid[e] = 0;
                dir_dirty[e] = 0;
                dir_tag[e]   = '0;
                if (!plru_mode)
                    for (int w = 0; w < WAY_COUNT; w++)
                        if (dir_valid[base+w] && dir_age[base+w] > old)
                            dir_age[base+w] = dir_age[base+w] - 1'b1;
                dir_age[e] = '0;
                r.outcome  = OUT_INV_HIT;
                r.way_used = WAY_W'(hw);
            end else begin
                r.outcome = OUT_INV_MISS;
            end
        end else if (hit) begin
            e = base + hw;
            if (wr) dir_dirty[e] = 1;
            if (!plru_mode) begin
                old = dir_age[e];
                for (int w = 0; w < WAY_COUNT; w++)
                    if (dir_valid[base+w] && dir_age[base+w] < old) age_up(base + w);
                dir_age[e] = '0;
            end else begin
                dir_age[e] = 1;
            end
            r.outcome  = OUT_HIT;
            r.way_used = WAY_W'(hw);
        end else begin
            found = 0;
            for (int w = 0; w < WAY_COUNT; w++)
                if (!found && !dir_valid[base+w]) begin
                    found = 1;
                    way   = w;
                end
            if (found) begin
                e = base + way;
                dir_tag[e]   = tg;
                dir_valid[e] = 1;
                dir_dirty[e] = wr;
                if (!plru_mode) begin
                    for (int w = 0; w < WAY_COUNT; w++)
                        if (dir_valid[base+w]) age_up(base + w);
                    dir_age[e] = '0;
                end else begin
                    plru_clear_if_full(base);
                    dir_age[e] = 1;
                end
                r.outcome = OUT_FILL;
            end else begin
                if (!plru_mode) begin
                    best = dir_age[base];
                    for (int w = 1; w < WAY_COUNT; w++)
                        if (dir_age[base+w] > best) begin
                            best = dir_age[base+w];
                            way  = w;
                        end
                    for (int w = 0; w < WAY_COUNT; w++) if (w != way) age_up(base + w);
                    dir_age[base+way] = '0;
                end else begin
                    plru_clear_if_full(base);
                    found = 0;
                    for (int w = 0; w < WAY_COUNT; w++)
                        if (!found && dir_age[base+w] == 0) begin
                            found = 1;
                            way   = w;
                        end
                    dir_age[base+way] = 1;
                end
                e = base + way;
                if (dir_dirty[e]) begin
                    r.writeback  = 1'b1;
                    r.victim_tag = dir_tag[e];
                end
                dir_tag[e]   = tg;
                dir_valid[e] = 1;
                dir_dirty[e] = wr;
                r.outcome    = OUT_EVICT;
            end
            r.way_used = WAY_W'(way);
        end
        return r;
    endfunction

    initial begin
        for (int e = 0; e < ENTRIES; e++) begin
            dir_tag[e]   = '0;
            dir_valid[e] = 0;
            dir_dirty[e] = 0;
            dir_age[e]   = '0;
        end
        plru_mode    = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if (i_res_valid) begin
                got = '{i_outcome, i_way_used, i_writeback, i_victim_tag};
                if (lookup_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = lookup_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) plru_mode = i_cfg_mode;
            if (i_start && !i_busy) lookup_q.push_back(lookup(i_cmd, i_address));
            o_pending <= lookup_q.size();
        end
    end

endmodule

>>> tb/tb_set_assoc_cache_tag_directory.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_directory
// Drives the tag directory with directed and random requests under both
// replacement modes; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_directory;
    import sacd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_INVAL = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_address = '0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_replacement_mode = 0;
    logic        o_valid;
    logic [2:0]  o_outcome;
    logic [2:0]  o_way_used;
    logic        o_writeback;
    logic [15:0] o_victim_tag;
    int          fail_count, pending, cycles;
    bit          no_gaps;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    set_assoc_cache_tag_directory uut (.*);

    cache_dir_checker checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cmd, .i_address,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_mode(i_cfg_replacement_mode),
        .i_res_valid(o_valid), .i_outcome(o_outcome), .i_way_used(o_way_used),
        .i_writeback(o_writeback), .i_victim_tag(o_victim_tag),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] make_addr(int tg, int set_no);
        return {16'(tg), 10'(set_no), 6'($urandom)};
    endfunction

    task automatic request(logic [1:0] cmd, logic [31:0] addr);
        if (!no_gaps)
            while ($urandom_range(0, 99) < 25) begin
                start <= 0;
                @(posedge i_clk);
            end
        start     <= 1;
        i_cmd     <= cmd;
        i_address <= addr;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        drain();
        i_cfg_valid            <= 1;
        i_cfg_replacement_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    task automatic random_items(int n);
        int r, tg, sn;
        for (int k = 0; k < n; k++) begin
            no_gaps = (k >= 60 && k < 120);
            r  = $urandom_range(0, 99);
            tg = ($urandom_range(0, 9) == 0) ? 16'hFFFF : $urandom_range(0, 11);
            sn = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 3);
            request(2'($urandom_range(0, 99) < 80 ? $urandom_range(0, 1)
                                                   : $urandom_range(2, 3)),
                    r < 90 ? make_addr(tg, sn) : $urandom);
        end
        no_gaps = 0;
    endtask

    initial begin
        cycles  = 0;
        no_gaps = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        set_mode(0);
        // extremes, every command, fill past capacity, dirty eviction
        request(CMD_READ, 32'h0000_0000);
        request(CMD_WRITE, 32'hFFFF_FFFF);
        request(CMD_READ, 32'hFFFF_FFC0);
        request(CMD_INVAL, 32'hFFFF_FFFF);
        request(CMD_INVAL, 32'hFFFF_FFFF);
        request(CMD_SPARE, 32'h0000_0000);
        for (int t = 0; t < 9; t++) request(t[0] ? CMD_WRITE : CMD_READ, make_addr(t + 1, 5));
        request(CMD_READ, make_addr(3, 5));
        request(CMD_WRITE, make_addr(12, 5));
        request(CMD_INVAL, make_addr(4, 5));
        request(CMD_WRITE, make_addr(13, 5));
        set_mode(1);
        for (int t = 0; t < 6; t++) request(CMD_WRITE, make_addr(t + 20, 5));
        random_items(250);
        set_mode(0);
        random_items(250);
        drain();
        random_items(250);
        set_mode(1);
        random_items(150);
        set_mode(0);
        random_items(120);
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
